/* hdl/sgrt_pkg.sv */
// Shared constants, types and status codes for the sample group run table.
package sgrt_pkg;

	localparam int unsigned MAX_TYPES_DEF = 4;
	localparam int unsigned MAX_RUNS_DEF  = 64;
	localparam logic [31:0] SN_ALL        = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_NOT_SUPPORTED = 2'd1,
		ST_FULL          = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_READ,
		S_DECIDE,
		S_WRITE2,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic lookup;
		logic mem_read;
		logic decide;
		logic write2;
		logic respond;
	} ctl_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic need_write2;
	} ctl_sts_t;

endpackage

/* hdl/sample_group_run_table_top.sv */
// Top level of the sample group run table.
//  channel | signals                                   | handshake
//  input   | sample_no .. track_samples                | start & !busy
//  result  | status, run_count, covered_samples        | done, one-cycle strobe
// After the accepting edge the controller steps through slot lookup, run memory
// read, decision with the first write, an optional second write, then the response.
// done is registered from the response state, so it rises as the controller returns
// to idle; busy falls as done rises, so one word is finished before the next is taken.
// Reset clears the slot valid bits and counters; the run memory is not cleared.
// The receiver cannot stall results.
module sample_group_run_table_top #(
	parameter int unsigned MAX_TYPES = sgrt_pkg::MAX_TYPES_DEF,
	parameter int unsigned MAX_RUNS  = sgrt_pkg::MAX_RUNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] sample_no,
	input  logic [31:0] group_code,
	input  logic [31:0] grouping_param,
	input  logic [31:0] desc_index,
	input  logic        has_sample_table,
	input  logic [31:0] track_samples,
	output logic        done,
	output logic [1:0]  status,
	output logic [6:0]  run_count,
	output logic [31:0] covered_samples
);
	import sgrt_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	sgrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .sts(sts)
	);

	sgrt_dpath #(.MAX_TYPES(MAX_TYPES), .MAX_RUNS(MAX_RUNS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.sample_no(sample_no), .group_code(group_code),
		.grouping_param(grouping_param), .desc_index(desc_index),
		.has_sample_table(has_sample_table), .track_samples(track_samples),
		.done(done), .status(status), .run_count(run_count),
		.covered_samples(covered_samples)
	);
endmodule

/* hdl/sgrt_ctrl.sv */
// Controller state machine that sequences one word through the datapath.
module sgrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output sgrt_pkg::ctl_cmd_t cmd,
	input  sgrt_pkg::ctl_sts_t sts
);
	import sgrt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.capture = start;
				if (start) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = S_READ;
			end
			S_READ: begin
				cmd.mem_read = 1'b1;
				state_d      = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.need_write2 ? S_WRITE2 : S_DONE;
			end
			S_WRITE2: begin
				cmd.write2 = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				cmd.respond = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* hdl/sgrt_dpath.sv */
// Datapath: type slots, run memory and the update decision.
module sgrt_dpath #(
	parameter int unsigned MAX_TYPES = sgrt_pkg::MAX_TYPES_DEF,
	parameter int unsigned MAX_RUNS  = sgrt_pkg::MAX_RUNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sgrt_pkg::ctl_cmd_t cmd,
	output sgrt_pkg::ctl_sts_t sts,
	input  logic [31:0]        sample_no,
	input  logic [31:0]        group_code,
	input  logic [31:0]        grouping_param,
	input  logic [31:0]        desc_index,
	input  logic               has_sample_table,
	input  logic [31:0]        track_samples,
	output logic               done,
	output logic [1:0]         status,
	output logic [6:0]         run_count,
	output logic [31:0]        covered_samples
);
	import sgrt_pkg::*;

	localparam int unsigned SW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
	localparam int unsigned RW = $clog2(MAX_RUNS);
	localparam int unsigned CW = $clog2(MAX_RUNS + 1);
	localparam int unsigned AW = SW + RW;
	localparam int unsigned DEPTH = 1 << AW;

	logic [31:0] sn_q, type_q, par_q, desc_q, track_q;
	logic        stbl_q;

	logic [MAX_TYPES-1:0] tvalid_q;
	logic [31:0]          tcode_q  [MAX_TYPES];
	logic [31:0]          tparam_q [MAX_TYPES];
	logic [CW-1:0]        truns_q  [MAX_TYPES];
	logic [31:0]          ttotal_q [MAX_TYPES];

	logic [31:0] len_mem [DEPTH];
	logic [31:0] idx_mem [DEPTH];

	logic [SW-1:0] slot_q;
	logic          nofree_q, isnew_q;
	logic [31:0]   last_len_q, last_idx_q;
	logic [CW-1:0] runs_q;
	logic [31:0]   total_q;

	// Second write held for the gap-then-run case.
	logic [AW-1:0] w2_addr_q;
	logic [31:0]   w2_len_q, w2_idx_q;

	logic [1:0]  st_q;
	logic [6:0]  rc_q;
	logic [31:0] cov_q;
	logic        done_q;

	// Lookup: first matching slot, otherwise first free slot.
	logic [SW-1:0] hit_slot, free_slot;
	logic          hit, free_found;
	always_comb begin
		hit = 1'b0; free_found = 1'b0; hit_slot = '0; free_slot = '0;
		for (int i = 0; i < MAX_TYPES; i++) begin
			if (!hit && tvalid_q[i] && tcode_q[i] == type_q) begin
				hit = 1'b1; hit_slot = SW'(i);
			end
			if (!free_found && !tvalid_q[i]) begin
				free_found = 1'b1; free_slot = SW'(i);
			end
		end
	end

	// The last run is addressed from the live slot counter, which already
	// holds the selected slot's count when the memory is read.
	logic [CW-1:0] runs_m1;
	logic [AW-1:0] last_addr;
	assign runs_m1   = truns_q[slot_q] - CW'(1);
	assign last_addr = {slot_q, runs_m1[RW-1:0]};

	// Decision logic.
	logic [31:0]   sn, gap;
	logic          all_mode;
	logic          we1, we2;
	logic [AW-1:0] a1, a2;
	logic [31:0]   l1, i1, l2, i2;
	logic [CW-1:0] new_runs;
	logic [31:0]   new_total;
	logic [1:0]    st;
	logic          upd;
	always_comb begin
		all_mode = 1'b0;
		if (sn_q == '0) sn = total_q + 32'd1;
		else if (sn_q == SN_ALL) begin sn = 32'd1; all_mode = 1'b1; end
		else sn = sn_q;
		gap = sn - 32'd1 - total_q;
		we1 = 1'b0; we2 = 1'b0; upd = 1'b0;
		a1 = last_addr; a2 = '0;
		l1 = '0; i1 = '0; l2 = '0; i2 = '0;
		new_runs = runs_q; new_total = total_q;
		st = ST_OK;
		if (runs_q == '0) begin
			upd = 1'b1;
			if (sn > 32'd1) begin
				we1 = 1'b1; a1 = {slot_q, RW'(0)}; l1 = sn - 32'd1;
				i1 = (desc_q != '0) ? 32'd0 : 32'd1;
				we2 = 1'b1; a2 = {slot_q, RW'(1)}; l2 = 32'd1; i2 = desc_q;
				new_runs = CW'(2);
			end else begin
				we1 = 1'b1; a1 = {slot_q, RW'(0)};
				l1 = (all_mode && stbl_q) ? track_q : 32'd1; i1 = desc_q;
				new_runs = CW'(1);
			end
			new_total = (all_mode && stbl_q) ? track_q : sn;
		end else if (all_mode && stbl_q) begin
			upd = 1'b1; we1 = 1'b1; a1 = {slot_q, RW'(0)};
			l1 = track_q; i1 = desc_q;
			new_runs = CW'(1); new_total = track_q;
		end else if (total_q > sn) begin
			st = ST_NOT_SUPPORTED;
		end else if (total_q == sn) begin
			st = (last_idx_q == desc_q) ? ST_OK : ST_NOT_SUPPORTED;
		end else if (last_idx_q == desc_q && gap == '0) begin
			upd = 1'b1; we1 = 1'b1; l1 = last_len_q + 32'd1; i1 = last_idx_q;
			new_total = total_q + 32'd1;
		end else if (last_idx_q == '0) begin
			if (runs_q >= CW'(MAX_RUNS)) st = ST_FULL;
			else begin
				upd = 1'b1; we1 = 1'b1; l1 = last_len_q + gap; i1 = last_idx_q;
				we2 = 1'b1; a2 = {slot_q, runs_q[RW-1:0]}; l2 = 32'd1; i2 = desc_q;
				new_runs = runs_q + CW'(1); new_total = sn;
			end
		end else if (desc_q == '0 || gap == '0) begin
			if (runs_q >= CW'(MAX_RUNS)) st = ST_FULL;
			else begin
				upd = 1'b1; we1 = 1'b1; a1 = {slot_q, runs_q[RW-1:0]};
				l1 = 32'd1; i1 = desc_q;
				new_runs = runs_q + CW'(1); new_total = total_q + 32'd1;
			end
		end else begin
			if (runs_q >= CW'(MAX_RUNS - 1)) st = ST_FULL;
			else begin
				upd = 1'b1; we1 = 1'b1; a1 = {slot_q, runs_q[RW-1:0]};
				l1 = gap; i1 = 32'd0;
				we2 = 1'b1; a2 = {slot_q, runs_m1[RW-1:0] + RW'(2)};
				l2 = 32'd1; i2 = desc_q;
				new_runs = runs_q + CW'(2); new_total = sn;
			end
		end
		if (nofree_q) begin
			st = ST_FULL; upd = 1'b0; we1 = 1'b0; we2 = 1'b0;
		end
	end

	assign sts.need_write2 = we2;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sn_q <= sample_no; type_q <= group_code; par_q <= grouping_param;
			desc_q <= desc_index; stbl_q <= has_sample_table; track_q <= track_samples;
		end
		if (cmd.lookup) begin
			slot_q   <= hit ? hit_slot : free_slot;
			nofree_q <= !hit && !free_found;
			isnew_q  <= !hit && free_found;
		end
		if (cmd.decide) begin
			w2_addr_q <= a2; w2_len_q <= l2; w2_idx_q <= i2;
			st_q  <= st;
			rc_q  <= nofree_q ? 7'd0 : 7'(new_runs);
			cov_q <= nofree_q ? 32'd0 : new_total;
		end
		if (cmd.mem_read) begin
			last_len_q <= len_mem[last_addr];
			last_idx_q <= idx_mem[last_addr];
		end
		if (cmd.decide && we1) begin
			len_mem[a1] <= l1;
			idx_mem[a1] <= i1;
		end else if (cmd.write2) begin
			len_mem[w2_addr_q] <= w2_len_q;
			idx_mem[w2_addr_q] <= w2_idx_q;
		end
	end

	// Slot registers; a newly created slot starts empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= '0;
			for (int i = 0; i < MAX_TYPES; i++) begin
				truns_q[i] <= '0; ttotal_q[i] <= '0;
			end
		end else begin
			if (cmd.lookup && !hit && free_found) begin
				tvalid_q[free_slot] <= 1'b1;
				truns_q[free_slot]  <= '0;
				ttotal_q[free_slot] <= '0;
			end
			if (cmd.decide && upd) begin
				truns_q[slot_q]  <= new_runs;
				ttotal_q[slot_q] <= new_total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup && !hit && free_found) begin
			tcode_q[free_slot]  <= type_q;
			tparam_q[free_slot] <= par_q;
		end
	end

	// Slot counters are copied out in the read state that follows lookup.
	always_ff @(posedge clk) begin
		if (cmd.mem_read) begin
			runs_q  <= truns_q[slot_q];
			total_q <= ttotal_q[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= cmd.respond;
	end

	assign done            = done_q;
	assign status          = st_q;
	assign run_count       = rc_q;
	assign covered_samples = cov_q;

	logic unused;
	assign unused = isnew_q ^ tparam_q[0][0];
endmodule

/* test/testbench.sv */
// Testbench for the sample group run table: directed table plus random words against a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sgrt_pkg::*;

	localparam int NTYPES = 4;
	localparam int NRUNS = 64;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [31:0] sample_no = '0;
	logic [31:0] group_code = '0;
	logic [31:0] grouping_param = '0;
	logic [31:0] desc_index = '0;
	logic has_sample_table = 1'b0;
	logic [31:0] track_samples = '0;
	logic done;
	logic [1:0] status;
	logic [6:0] run_count;
	logic [31:0] covered_samples;

	sample_group_run_table_top dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	typedef struct {
		logic [1:0] st;
		logic [6:0] runs;
		logic [31:0] covered;
	} outcome_t;

	typedef struct {
		logic [31:0] sn, gtype, gparam, desc;
		logic stbl;
		logic [31:0] track;
		bit fixed;
		outcome_t want;
	} row_t;

	// Predictor state.
	bit slot_used[NTYPES];
	logic [31:0] slot_code[NTYPES];
	logic [31:0] slot_runs[NTYPES];
	logic [31:0] slot_total[NTYPES];
	logic [31:0] len_mem[NTYPES][NRUNS];
	logic [31:0] idx_mem[NTYPES][NRUNS];

	outcome_t pending[$];
	int errors = 0;
	int idle_pct = 0;
	int quiet = 0;

	function automatic status_t group_sample(int s, logic [31:0] sn0, logic [31:0] desc,
			logic stbl, logic [31:0] track);
		logic [31:0] total, runs, sn, gap;
		bit all;
		int last;
		int pos;
		total = slot_total[s];
		runs = slot_runs[s];
		sn = sn0;
		all = 0;
		if (sn == 0) sn = total + 1;
		else if (sn == SN_ALL) begin
			all = 1;
			sn = 1;
		end
		if (runs == 0) begin
			pos = 0;
			if (sn > 1) begin
				len_mem[s][0] = sn - 1;
				idx_mem[s][0] = (desc != 0) ? 32'd0 : 32'd1;
				pos = 1;
			end
			len_mem[s][pos] = (all && stbl) ? track : 32'd1;
			idx_mem[s][pos] = desc;
			slot_runs[s] = pos + 1;
			slot_total[s] = (all && stbl) ? track : sn;
			return ST_OK;
		end
		if (all && stbl) begin
			len_mem[s][0] = track;
			idx_mem[s][0] = desc;
			slot_runs[s] = 1;
			slot_total[s] = track;
			return ST_OK;
		end
		if (total > sn) return ST_NOT_SUPPORTED;
		last = runs - 1;
		if (total == sn) return (idx_mem[s][last] == desc) ? ST_OK : ST_NOT_SUPPORTED;
		gap = sn - 1 - total;
		if (idx_mem[s][last] == desc && gap == 0) begin
			len_mem[s][last] += 1;
			slot_total[s] = total + 1;
			return ST_OK;
		end
		if (idx_mem[s][last] == 0) begin
			if (runs + 1 > NRUNS) return ST_FULL;
			len_mem[s][last] += gap;
			len_mem[s][runs] = 1;
			idx_mem[s][runs] = desc;
			slot_runs[s] = runs + 1;
			slot_total[s] = sn;
			return ST_OK;
		end
		if (desc == 0 || gap == 0) begin
			if (runs + 1 > NRUNS) return ST_FULL;
			len_mem[s][runs] = 1;
			idx_mem[s][runs] = desc;
			slot_runs[s] = runs + 1;
			slot_total[s] = total + 1;
			return ST_OK;
		end
		if (runs + 2 > NRUNS) return ST_FULL;
		len_mem[s][runs] = gap;
		idx_mem[s][runs] = 0;
		len_mem[s][runs + 1] = 1;
		idx_mem[s][runs + 1] = desc;
		slot_runs[s] = runs + 2;
		slot_total[s] = sn;
		return ST_OK;
	endfunction

	function automatic outcome_t predict_word(row_t r);
		outcome_t o;
		int s;
		s = -1;
		for (int i = 0; i < NTYPES; i++)
			if (s < 0 && slot_used[i] && slot_code[i] == r.gtype) s = i;
		if (s < 0) begin
			for (int i = 0; i < NTYPES; i++)
				if (s < 0 && !slot_used[i]) s = i;
			if (s < 0) begin
				o.st = ST_FULL;
				o.runs = 0;
				o.covered = 0;
				return o;
			end
			slot_used[s] = 1;
			slot_code[s] = r.gtype;
			slot_runs[s] = 0;
			slot_total[s] = 0;
		end
		o.st = group_sample(s, r.sn, r.desc, r.stbl, r.track);
		o.runs = slot_runs[s][6:0];
		o.covered = slot_total[s];
		return o;
	endfunction

	// start stays high from one word to the next unless the sender idles.
	task automatic send_word(row_t r);
		outcome_t o;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		sample_no <= r.sn;
		group_code <= r.gtype;
		grouping_param <= r.gparam;
		desc_index <= r.desc;
		has_sample_table <= r.stbl;
		track_samples <= r.track;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		o = predict_word(r);
		pending.push_back(r.fixed ? r.want : o);
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (done) begin
			if (pending.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = pending.pop_front();
				if (status != e.st) begin
					$error("status expected %0d got %0d", e.st, status);
					errors++;
				end
				if (run_count != e.runs) begin
					$error("run_count expected %0d got %0d", e.runs, run_count);
					errors++;
				end
				if (covered_samples != e.covered) begin
					$error("covered_samples expected %0h got %0h", e.covered,
						covered_samples);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("[sample_group_run_table_top] ERROR");
			$finish;
		end
	end

	function automatic row_t mk(logic [31:0] sn, logic [31:0] gt, logic [31:0] d,
			logic stbl, logic [31:0] tr);
		row_t r;
		r.sn = sn;
		r.gtype = gt;
		r.gparam = $urandom;
		r.desc = d;
		r.stbl = stbl;
		r.track = tr;
		r.fixed = 0;
		return r;
	endfunction

	function automatic row_t mkx(logic [31:0] sn, logic [31:0] gt, logic [31:0] d,
			logic stbl, logic [31:0] tr, logic [1:0] st, logic [6:0] rc, logic [31:0] cv);
		row_t r;
		r = mk(sn, gt, d, stbl, tr);
		r.fixed = 1;
		r.want.st = st;
		r.want.runs = rc;
		r.want.covered = cv;
		return r;
	endfunction

	row_t directed[$];
	logic [31:0] codes[6];

	initial begin
		row_t r;
		int n;
		// Sample, type, index, table flag, track count, then for mkx rows the expected results.
		directed = '{
			mkx(0, 32'h7365_6967, 5, 0, 0, ST_OK, 1, 1),
			mkx(0, 32'h7365_6967, 5, 0, 0, ST_OK, 1, 2),
			mkx(1, 32'h7365_6967, 9, 0, 0, ST_NOT_SUPPORTED, 1, 2),
			mkx(2, 32'h7365_6967, 5, 0, 0, ST_OK, 1, 2),
			mkx(2, 32'h7365_6967, 6, 0, 0, ST_NOT_SUPPORTED, 1, 2),
			mk(10, 32'h7365_6967, 6, 0, 0),
			mk(11, 32'h7365_6967, 0, 0, 0),
			mk(20, 32'h7365_6967, 3, 0, 0),
			mk(0, 32'h7365_6967, 7, 0, 0),
			mkx(5, 32'hFFFF_FFFF, 0, 0, 0, ST_OK, 2, 5),
			mk(9, 32'hFFFF_FFFF, 4, 1, 32'hFFFF_FFFF),
			mkx(SN_ALL, 32'h0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
				ST_OK, 1, 32'hFFFF_FFFF),
			mk(0, 32'h0, 32'hFFFF_FFFF, 0, 0),
			mk(SN_ALL, 32'h0, 1, 0, 7),
			mkx(SN_ALL, 32'h1234, 8, 0, 3, ST_OK, 1, 1),
			mkx(0, 32'h5555, 1, 0, 0, ST_FULL, 0, 0),
			mk(SN_ALL, 32'h1234, 2, 1, 0),
			mk(32'hFFFF_FFFE, 32'h1234, 2, 0, 0),
			mk(0, 32'h1234, 2, 0, 0)
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_word(directed[i]);

		// Random words fill run tables towards full.
		codes = '{32'h7365_6967, 32'hFFFF_FFFF, 32'h0, 32'h1234, 32'hA5A5_5A5A, 32'h0};
		for (n = 0; n < 650; n++) begin
			if (n == 220) idle_pct = 49;
			else if (n == 440) idle_pct = 0;
			else if (n == 0) idle_pct = 20;
			if (n % 60 == 0) codes[5] = $urandom;
			r = mk(0, codes[$urandom_range(5)], $urandom_range(4), 1'($urandom_range(1)),
				$urandom_range(40));
			case ($urandom_range(9))
				0: r.sn = $urandom;
				1: r.sn = SN_ALL;
				2, 3: r.sn = 0;
				default: r.sn = $urandom_range(300);
			endcase
			if ($urandom_range(9) == 0) r.desc = $urandom;
			if ($urandom_range(9) == 0) r.track = $urandom;
			send_word(r);
		end
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("[sample_group_run_table_top] OK");
		else $display("[sample_group_run_table_top] ERROR");
		$finish;
	end
endmodule

/* sim.f */
hdl/sgrt_pkg.sv
hdl/sgrt_ctrl.sv
hdl/sgrt_dpath.sv
hdl/sample_group_run_table_top.sv
test/testbench.sv
